// ----- rtl/tuc_pkg.sv -----
// Package for the text Unicode classifier: shared constants, flag codes and
// the work-entry types that pass from the byte front end to the result back end.
// No dependencies.
package tuc_pkg;

	localparam int UNIT_BYTES = 4;
	localparam int UNIT_W     = 8 * UNIT_BYTES;
	localparam int PART_W     = 8 * (UNIT_BYTES - 1);
	localparam int PHASE_W    = $clog2(UNIT_BYTES);
	localparam int SAT_W      = $clog2(UNIT_BYTES + 1);
	localparam int MAX_UNITS  = 256;
	localparam int CNT_W      = $clog2(MAX_UNITS + 1);
	localparam int Q_DEPTH    = 4;
	localparam int Q_AW       = $clog2(Q_DEPTH);
	localparam int Q_CW       = $clog2(Q_DEPTH + 1);

	localparam logic [15:0] MASK_RESET      = 16'hFFFF;
	localparam logic [15:0] F_STATISTICS    = 16'h0002;
	localparam logic [15:0] F_CONTROLS      = 16'h0004;
	localparam logic [15:0] F_SIGNATURE     = 16'h0008;
	localparam logic [15:0] F_REV_CONTROLS  = 16'h0040;
	localparam logic [15:0] F_REV_SIGNATURE = 16'h0080;
	localparam logic [15:0] F_ODD_LENGTH    = 16'h0200;
	localparam logic [15:0] F_NULL_BYTES    = 16'h1000;
	localparam logic [15:0] VERDICT_NO      = 16'h0FF0;
	localparam logic [15:0] VERDICT_YES     = 16'hF00F;

	localparam logic [UNIT_W-1:0] U_BOM     = UNIT_W'(32'hFEFF);
	localparam logic [UNIT_W-1:0] U_REV_BOM = UNIT_W'(32'hFFFE);

	// One entry per accepted byte.
	typedef struct packed {
		logic examine;   // a full unit was completed and is to be examined
		logic narrow;    // unit value at most 0xFF
		logic nul;       // unit has a zero low byte or a zero upper part
		logic ctrl;      // standard control or space
		logic rev_ctrl;  // byte-reversed control or space
		logic last;      // final byte of the buffer
		logic sig;       // byte-order mark seen in the first unit
		logic rev_sig;   // reversed byte-order mark seen in the first unit
		logic odd;       // byte count so far is odd
		logic short_buf; // fewer than one unit of bytes so far
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- rtl/tuc_front.sv -----
// Front end of the text Unicode classifier: assembles little-endian units
// from bytes and classifies each completed unit into a work entry.
// Depends on tuc_pkg.
module tuc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      data_byte,
	input  logic            last,
	input  tuc_pkg::q_stat_t q_stat,
	output logic            push_valid,
	output tuc_pkg::work_t  push_entry
);

	logic [tuc_pkg::PHASE_W-1:0] phase_q;
	logic [tuc_pkg::SAT_W-1:0]   sat_q, sat_nxt;
	logic                        odd_q;
	logic                        first_done_q;
	logic                        sig_q, rev_sig_q, sig_nxt, rev_sig_nxt;
	logic [tuc_pkg::PART_W-1:0]  partial_q;
	logic [tuc_pkg::UNIT_W-1:0]  unit;
	logic                        unit_done;
	logic                        take;

	assign in_ready   = !q_stat.full;
	assign take       = in_valid && in_ready;
	assign push_valid = take;

	assign unit_done = (phase_q == tuc_pkg::PHASE_W'(tuc_pkg::UNIT_BYTES - 1));
	assign unit      = {data_byte, partial_q};
	assign sat_nxt   = (sat_q < tuc_pkg::SAT_W'(tuc_pkg::UNIT_BYTES)) ?
		sat_q + tuc_pkg::SAT_W'(1) : sat_q;

	always_comb begin
		sig_nxt     = sig_q;
		rev_sig_nxt = rev_sig_q;
		if (unit_done && !first_done_q) begin
			sig_nxt     = sig_q || (unit == tuc_pkg::U_BOM);
			rev_sig_nxt = rev_sig_q || (unit == tuc_pkg::U_REV_BOM);
		end
	end

	always_comb begin
		push_entry.examine   = unit_done && !(last && data_byte == 8'h00);
		push_entry.narrow    = (unit[tuc_pkg::UNIT_W-1:8] == '0);
		push_entry.nul       = (unit[7:0] == 8'h00) || (unit[tuc_pkg::UNIT_W-1:8] == '0);
		push_entry.ctrl      = (unit == tuc_pkg::UNIT_W'(32'h0D)) ||
			(unit == tuc_pkg::UNIT_W'(32'h0A)) || (unit == tuc_pkg::UNIT_W'(32'h09)) ||
			(unit == tuc_pkg::UNIT_W'(32'h20)) || (unit == tuc_pkg::UNIT_W'(32'h3000)) ||
			(unit == '0);
		push_entry.rev_ctrl  = (unit == tuc_pkg::UNIT_W'(32'h0D00)) ||
			(unit == tuc_pkg::UNIT_W'(32'h0A00)) || (unit == tuc_pkg::UNIT_W'(32'h0900)) ||
			(unit == tuc_pkg::UNIT_W'(32'h2000)) || (unit == '0);
		push_entry.last      = last;
		push_entry.sig       = sig_nxt;
		push_entry.rev_sig   = rev_sig_nxt;
		push_entry.odd       = !odd_q;
		push_entry.short_buf = (sat_nxt < tuc_pkg::SAT_W'(tuc_pkg::UNIT_BYTES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			sat_q        <= '0;
			odd_q        <= 1'b0;
			first_done_q <= 1'b0;
			sig_q        <= 1'b0;
			rev_sig_q    <= 1'b0;
			partial_q    <= '0;
		end else if (take) begin
			if (last) begin
				phase_q      <= '0;
				sat_q        <= '0;
				odd_q        <= 1'b0;
				first_done_q <= 1'b0;
				sig_q        <= 1'b0;
				rev_sig_q    <= 1'b0;
				partial_q    <= '0;
			end else begin
				sat_q     <= sat_nxt;
				odd_q     <= !odd_q;
				sig_q     <= sig_nxt;
				rev_sig_q <= rev_sig_nxt;
				if (unit_done) begin
					phase_q      <= '0;
					partial_q    <= '0;
					first_done_q <= 1'b1;
				end else begin
					phase_q   <= phase_q + tuc_pkg::PHASE_W'(1);
					partial_q <= partial_q |
						(tuc_pkg::PART_W'(data_byte) << {phase_q, 3'b000});
				end
			end
		end
	end

endmodule

// ----- rtl/tuc_queue.sv -----
// Short work queue between the classifier front end and back end.
// Depends on tuc_pkg.
module tuc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  tuc_pkg::work_t   push_entry,
	input  logic             pop,
	output tuc_pkg::work_t   pop_entry,
	output tuc_pkg::q_stat_t q_stat
);

	tuc_pkg::work_t            mem_q [tuc_pkg::Q_DEPTH];
	logic [tuc_pkg::Q_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [tuc_pkg::Q_CW-1:0]  count_q;
	logic                      do_push, do_pop;

	assign q_stat.full  = (count_q == tuc_pkg::Q_CW'(tuc_pkg::Q_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push_valid && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign pop_entry    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + tuc_pkg::Q_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + tuc_pkg::Q_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + tuc_pkg::Q_CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - tuc_pkg::Q_CW'(1);
			end
		end
	end

endmodule

// ----- rtl/tuc_back.sv -----
// Back end of the text Unicode classifier: accumulates unit statistics from
// work entries and forms the masked flags and verdict at the end of a buffer.
// Depends on tuc_pkg.
module tuc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tuc_pkg::q_stat_t q_stat,
	input  tuc_pkg::work_t   pop_entry,
	output logic             pop,
	input  logic [15:0]      mask,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [15:0]      result_flags,
	output logic             is_unicode
);

	logic [tuc_pkg::CNT_W-1:0] unit_cnt_q, narrow_cnt_q, unit_cnt_nxt, narrow_cnt_nxt;
	logic                      null_q, ctrl_q, rev_ctrl_q;
	logic                      null_nxt, ctrl_nxt, rev_ctrl_nxt;
	logic                      use_unit;
	logic                      out_free;
	logic [15:0]               flags;
	logic                      out_valid_q;
	logic [15:0]               flags_q;
	logic                      unicode_q;

	assign out_free = !out_valid_q || out_ready;
	assign pop      = !q_stat.empty && (!pop_entry.last || out_free);

	assign use_unit = pop_entry.examine &&
		(unit_cnt_q < tuc_pkg::CNT_W'(tuc_pkg::MAX_UNITS));

	always_comb begin
		unit_cnt_nxt   = unit_cnt_q;
		narrow_cnt_nxt = narrow_cnt_q;
		null_nxt       = null_q;
		ctrl_nxt       = ctrl_q;
		rev_ctrl_nxt   = rev_ctrl_q;
		if (use_unit) begin
			unit_cnt_nxt = unit_cnt_q + tuc_pkg::CNT_W'(1);
			if (pop_entry.narrow) begin
				narrow_cnt_nxt = narrow_cnt_q + tuc_pkg::CNT_W'(1);
			end
			null_nxt     = null_q || pop_entry.nul;
			ctrl_nxt     = ctrl_q || pop_entry.ctrl;
			rev_ctrl_nxt = rev_ctrl_q || pop_entry.rev_ctrl;
		end
	end

	always_comb begin
		flags = '0;
		if (!pop_entry.short_buf) begin
			if (pop_entry.sig)                      flags = flags | tuc_pkg::F_SIGNATURE;
			if (pop_entry.rev_sig)                  flags = flags | tuc_pkg::F_REV_SIGNATURE;
			if (pop_entry.odd)                      flags = flags | tuc_pkg::F_ODD_LENGTH;
			if (narrow_cnt_nxt > (unit_cnt_nxt >> 1)) flags = flags | tuc_pkg::F_STATISTICS;
			if (null_nxt)                           flags = flags | tuc_pkg::F_NULL_BYTES;
			if (ctrl_nxt)                           flags = flags | tuc_pkg::F_CONTROLS;
			if (rev_ctrl_nxt)                       flags = flags | tuc_pkg::F_REV_CONTROLS;
			flags = flags & mask;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_entry.last) begin
			flags_q   <= flags;
			unicode_q <= ((flags & tuc_pkg::VERDICT_NO) == '0) &&
				((flags & tuc_pkg::VERDICT_YES) != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_cnt_q   <= '0;
			narrow_cnt_q <= '0;
			null_q       <= 1'b0;
			ctrl_q       <= 1'b0;
			rev_ctrl_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				if (pop_entry.last) begin
					unit_cnt_q   <= '0;
					narrow_cnt_q <= '0;
					null_q       <= 1'b0;
					ctrl_q       <= 1'b0;
					rev_ctrl_q   <= 1'b0;
				end else begin
					unit_cnt_q   <= unit_cnt_nxt;
					narrow_cnt_q <= narrow_cnt_nxt;
					null_q       <= null_nxt;
					ctrl_q       <= ctrl_nxt;
					rev_ctrl_q   <= rev_ctrl_nxt;
				end
			end
			if (pop && pop_entry.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign result_flags = flags_q;
	assign is_unicode   = unicode_q;

endmodule

// ----- rtl/text_unicode_classifier.sv -----
// Top level of the text Unicode classifier: mask register, byte front end,
// work queue and result back end. Depends on tuc_pkg, tuc_front, tuc_queue
// and tuc_back.
//
//   channel   direction  handshake            word
//   in        input      in_valid/in_ready    data_byte, last
//   out       output     out_valid/out_ready  result_flags, is_unicode
//   cfg       input      cfg_valid/cfg_ready  request_mask
//
// The block takes one byte per cycle while the queue is not full. Each byte
// becomes one work word in a four-entry queue; the back end drains one word
// per cycle, a last word only when the output is free, so the rate is set by the
// queue and the back end's accumulators, one byte per cycle. The result is
// loaded into the output register at the edge where the last byte's word
// leaves the queue. Reset clears all buffer state and sets the mask to all
// ones. A stalled output holds the last word queued; earlier bytes flow on.
module text_unicode_classifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] result_flags,
	output logic        is_unicode,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] request_mask
);

	// The user must see that the mask is written only while the block is idle, so the
	// back end can read it directly when it forms a result; the block leaves it unchecked.
	logic [15:0]      mask_q;
	logic             push_valid;
	logic             pop;
	tuc_pkg::work_t   push_entry;
	tuc_pkg::work_t   pop_entry;
	tuc_pkg::q_stat_t q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= tuc_pkg::MASK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			mask_q <= request_mask;
		end
	end

	// Front end: unit assembly and classification, one byte a cycle if not full.
	tuc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.last       (last),
		.q_stat     (q_stat),
		.push_valid (push_valid),
		.push_entry (push_entry)
	);

	// Queue decouples byte intake from result delivery.
	tuc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.q_stat     (q_stat)
	);

	// Back end: counters, seen bits, masking and the verdict.
	tuc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.pop_entry    (pop_entry),
		.pop          (pop),
		.mask         (mask_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_flags (result_flags),
		.is_unicode   (is_unicode)
	);

	// A Unicode verdict never coexists with a failing-test flag.
	a_verdict_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_unicode && ((result_flags & tuc_pkg::VERDICT_NO) != '0)))
		else $error("verdict set with a failing flag");

	// Reported flags never include bits outside the mask.
	a_flags_masked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((result_flags & ~mask_q) == '0))
		else $error("flag outside mask reported");

	// The queue cannot look full and empty at once.
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty");

	// Back pressure on the input comes only from a full queue.
	a_ready_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_stat.full)
		else $error("input stalled with queue space");

	// A result is never produced while the queue was empty the cycle before.
	a_result_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!q_stat.empty))
		else $error("result without a queued word");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for text_unicode_classifier: streams byte buffers, predicts
// each buffer's kept flags and verdict, and checks every result word in order.
// Depends on tuc_pkg and the text_unicode_classifier RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 200;
	localparam int BYTE_GOAL     = 1225;
	localparam int RESULT_GOAL   = 16;
	localparam int PHASE_BUFFERS = 4;
	localparam int LONG_BUFFER_AT = 2;
	localparam int HOLD_AT       = 8;
	localparam int PAUSE_AT      = 14;

	// Unit values that count as standard controls, and as byte-reversed controls.
	localparam logic [31:0] U_NUL        = 32'h0000_0000;
	localparam logic [31:0] U_CR         = 32'h0000_000D;
	localparam logic [31:0] U_LF         = 32'h0000_000A;
	localparam logic [31:0] U_TAB        = 32'h0000_0009;
	localparam logic [31:0] U_SPACE      = 32'h0000_0020;
	localparam logic [31:0] U_IDEO_SPACE = 32'h0000_3000;
	localparam logic [31:0] U_REV_CR     = 32'h0000_0D00;
	localparam logic [31:0] U_REV_LF     = 32'h0000_0A00;
	localparam logic [31:0] U_REV_TAB    = 32'h0000_0900;
	localparam logic [31:0] U_REV_SPACE  = 32'h0000_2000;

	localparam logic [31:0] CTRL_UNITS [6] =
		'{U_CR, U_LF, U_TAB, U_SPACE, U_IDEO_SPACE, U_NUL};
	localparam logic [31:0] REV_CTRL_UNITS [5] =
		'{U_REV_CR, U_REV_LF, U_REV_TAB, U_REV_SPACE, U_NUL};

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic [15:0] flags;
		logic        uni;
	} verdict_t;

	// One row of the directed script: a byte, its last marker, and, where the
	// outcome is obvious, the verdict word typed in by hand.
	typedef struct packed {
		logic [7:0]  value;
		logic        fin;
		logic        typed;
		logic [15:0] flags;
		logic        uni;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        last;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] result_flags;
	logic        is_unicode;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] request_mask;

	text_unicode_classifier i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.last         (last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_flags (result_flags),
		.is_unicode   (is_unicode),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.request_mask (request_mask)
	);

	// Verdicts of buffers whose last byte has been accepted, oldest first.
	verdict_t awaited[$];
	int       failures = 0;
	logic     hold_request = 1'b0;
	logic     rx_quick = 1'b0;

	// Shadow of the classifier's own state for the buffer in flight.
	logic [15:0]                mask_shadow;
	int                         lane;
	int                         byte_tally;
	logic                       odd_len;
	logic [tuc_pkg::PART_W-1:0] held_bytes;
	int                         units_examined;
	int                         narrow_units;
	logic                       first_unit_seen;
	logic [15:0]                mark_flags;
	logic                       saw_null;
	logic                       saw_ctrl;
	logic                       saw_rev_ctrl;

	script_row_t script_rows [25];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic clear_buffer_tracking();
		lane            = 0;
		byte_tally      = 0;
		odd_len         = 1'b0;
		held_bytes      = '0;
		units_examined  = 0;
		narrow_units    = 0;
		first_unit_seen = 1'b0;
		mark_flags      = '0;
		saw_null        = 1'b0;
		saw_ctrl        = 1'b0;
		saw_rev_ctrl    = 1'b0;
	endtask

	// Advances the shadow state by one accepted byte. On the last byte of a
	// buffer it returns the verdict the block must report and starts afresh.
	task automatic classify_byte(input logic [7:0] value, input logic fin,
			output logic produced, output verdict_t verdict);
		logic [tuc_pkg::UNIT_W-1:0] u;
		logic [15:0]                flags;
		produced = 1'b0;
		verdict  = '0;
		odd_len  = ~odd_len;
		if (byte_tally < tuc_pkg::UNIT_BYTES) byte_tally++;
		if (lane == tuc_pkg::UNIT_BYTES - 1) begin
			u = {value, held_bytes};
			// The mark check looks at the first unit even when its last byte
			// is a closing zero that keeps it out of the statistics.
			if (!first_unit_seen) begin
				if (u == tuc_pkg::U_BOM) mark_flags |= tuc_pkg::F_SIGNATURE;
				if (u == tuc_pkg::U_REV_BOM) mark_flags |= tuc_pkg::F_REV_SIGNATURE;
				first_unit_seen = 1'b1;
			end
			if (!(fin && value == 8'h00) && units_examined < tuc_pkg::MAX_UNITS) begin
				if (u <= 32'h0000_00FF) narrow_units++;
				if (u[7:0] == 8'h00 || u[31:8] == '0) saw_null = 1'b1;
				foreach (CTRL_UNITS[i])
					if (u == CTRL_UNITS[i]) saw_ctrl = 1'b1;
				foreach (REV_CTRL_UNITS[i])
					if (u == REV_CTRL_UNITS[i]) saw_rev_ctrl = 1'b1;
				units_examined++;
			end
			held_bytes = '0;
			lane       = 0;
		end else begin
			held_bytes[8*lane +: 8] = value;
			lane++;
		end
		if (fin) begin
			flags = '0;
			if (byte_tally >= tuc_pkg::UNIT_BYTES) begin
				flags = mark_flags;
				if (odd_len) flags |= tuc_pkg::F_ODD_LENGTH;
				if (narrow_units > units_examined / 2) flags |= tuc_pkg::F_STATISTICS;
				if (saw_null) flags |= tuc_pkg::F_NULL_BYTES;
				if (saw_ctrl) flags |= tuc_pkg::F_CONTROLS;
				if (saw_rev_ctrl) flags |= tuc_pkg::F_REV_CONTROLS;
				flags &= mask_shadow;
			end
			verdict.flags = flags;
			verdict.uni   = ((flags & tuc_pkg::VERDICT_NO) == '0) &&
				((flags & tuc_pkg::VERDICT_YES) != '0);
			produced      = 1'b1;
			clear_buffer_tracking();
		end
	endtask

	// Offers one byte after an optional gap and holds it until accepted.
	// Called and returns at a falling edge.
	task automatic send_byte(input logic [7:0] value, input logic fin, input int gap,
			input logic typed, input logic [15:0] typed_flags, input logic typed_uni);
		logic     produced;
		verdict_t predicted;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= value;
		last      <= fin;
		do @(posedge clk); while (!in_ready);
		classify_byte(value, fin, produced, predicted);
		if (produced) begin
			if (typed) begin
				predicted.flags = typed_flags;
				predicted.uni   = typed_uni;
			end
			awaited.push_back(predicted);
		end
		@(negedge clk);
	endtask

	task automatic send_text(input byte_q_t text);
		logic quick;
		quick = ($urandom_range(0, 3) == 0);
		foreach (text[i])
			send_byte(text[i], i == text.size() - 1, quick ? 0 : $urandom_range(0, 7),
				1'b0, '0, 1'b0);
	endtask

	// Stops offering bytes until every pending verdict is back, then lets the
	// block's pipeline run dry before anything else happens.
	task automatic await_idle();
		in_valid <= 1'b0;
		while (awaited.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_mask(input logic [15:0] mask);
		cfg_valid    <= 1'b1;
		request_mask <= mask;
		do @(posedge clk); while (!cfg_ready);
		mask_shadow = mask;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Favors unit values that trip one of the tests, with plain noise mixed in.
	function automatic logic [31:0] pick_unit();
		case ($urandom_range(0, 9))
			0: return tuc_pkg::U_BOM;
			1: return tuc_pkg::U_REV_BOM;
			2: return 32'($urandom_range(0, 255));
			3: return 32'($urandom_range(0, 16'hFFFF));
			4: return {24'($urandom), 8'h00};
			5: return CTRL_UNITS[$urandom_range(0, 5)];
			6: return REV_CTRL_UNITS[$urandom_range(0, 4)];
			7: return {8'h00, 24'($urandom)};
			default: return 32'($urandom);
		endcase
	endfunction

	// Mostly whole units with a short ragged tail; a quarter are raw noise.
	function automatic byte_q_t make_text();
		byte_q_t     text;
		logic [31:0] u;
		int          units;
		int          extra;
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 12)) text.push_back(8'($urandom));
		end else begin
			units = $urandom_range(0, 5);
			extra = $urandom_range(units == 0 ? 1 : 0, 3);
			repeat (units) begin
				u = pick_unit();
				for (int i = 0; i < tuc_pkg::UNIT_BYTES; i++) text.push_back(u[8*i +: 8]);
			end
			repeat (extra) text.push_back(8'($urandom));
		end
		return text;
	endfunction

	// A buffer longer than the unit cap. The capped units are wide and free of
	// nulls and controls; the zero units past the cap would set the null and
	// control flags if the block kept examining.
	function automatic byte_q_t make_long_text();
		byte_q_t     text;
		logic [31:0] u;
		repeat (tuc_pkg::MAX_UNITS) begin
			u = {8'($urandom), 8'($urandom), 8'($urandom_range(1, 255)),
				8'($urandom_range(1, 255))};
			for (int i = 0; i < tuc_pkg::UNIT_BYTES; i++) text.push_back(u[8*i +: 8]);
		end
		repeat ($urandom_range(1, 6) * tuc_pkg::UNIT_BYTES) text.push_back(8'h00);
		text.push_back(8'h41);
		return text;
	endfunction

	// Result side: draws a wait before each word, sometimes runs without
	// waits, and once holds off long enough for the block to back up.
	initial begin
		int   gap;
		logic hold_served;
		hold_served = 1'b0;
		out_ready   = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_request && !hold_served) begin
				hold_served = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if ($urandom_range(0, 15) == 0) rx_quick = ~rx_quick;
				gap = rx_quick ? 0 : $urandom_range(0, 7);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			@(negedge clk);
		end
	end

	// Every accepted result word is matched against the oldest pending verdict.
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited.size() == 0) begin
				$error("unexpected word: result_flags %h is_unicode %b",
					result_flags, is_unicode);
				failures++;
			end else begin
				want = awaited.pop_front();
				if (result_flags !== want.flags) begin
					$error("result_flags: expected %h, got %h", want.flags, result_flags);
					failures++;
				end
				if (is_unicode !== want.uni) begin
					$error("is_unicode: expected %b, got %b", want.uni, is_unicode);
					failures++;
				end
			end
		end
	end

	initial begin
		script_row_t row;
		byte_q_t     text;
		int          bytes_sent;
		int          buffers_sent;
		int          k;
		logic [15:0] next_mask;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		data_byte    = '0;
		last         = 1'b0;
		cfg_valid    = 1'b0;
		request_mask = tuc_pkg::MASK_RESET;
		mask_shadow  = tuc_pkg::MASK_RESET;
		clear_buffer_tracking();

		// Directed buffers, all under the reset mask: a one-byte buffer of all
		// ones, a two-byte buffer of zeros, a byte-order mark and a reversed
		// one each closed by a zero byte, an all-zero unit with an odd tail,
		// and standard and reversed controls with an odd tail.
		script_rows = '{
			'{8'hFF, 1'b1, 1'b1, 16'h0000, 1'b0},
			'{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
			'{8'h00, 1'b1, 1'b1, 16'h0000, 1'b0},
			'{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
			'{8'hFE, 1'b0, 1'b0, 16'h0000, 1'b0},
			'{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
			'{8'h00, 1'b1, 1'b1, tuc_pkg::F_SIGNATURE, 1'b1},
			'{8'hFE, 1'b0, 1'b0, 16'h0000, 1'b0},
			'{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
			'{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
			'{8'h00, 1'b1, 1'b1, tuc_pkg::F_REV_SIGNATURE, 1'b0},
			'{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
			'{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
			'{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
			'{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
			'{8'h01, 1'b1, 1'b1, 16'h1246, 1'b0},
			'{8'h0D, 1'b0, 1'b0, 16'h0000, 1'b0},
			'{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
			'{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
			'{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
			'{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
			'{8'h09, 1'b0, 1'b0, 16'h0000, 1'b0},
			'{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
			'{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
			'{8'h41, 1'b1, 1'b0, 16'h0000, 1'b0}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script_rows[i]) begin
			row = script_rows[i];
			send_byte(row.value, row.fin, $urandom_range(0, 7), row.typed, row.flags, row.uni);
		end

		// Random buffers in phases; each phase starts from an idle block with
		// a new mask, the extremes included.
		k            = 0;
		bytes_sent   = 0;
		buffers_sent = 0;
		while (bytes_sent < BYTE_GOAL || buffers_sent < RESULT_GOAL) begin
			if (k % PHASE_BUFFERS == 0) begin
				await_idle();
				case ((k / PHASE_BUFFERS) % 6)
					0: next_mask = tuc_pkg::MASK_RESET;
					1: next_mask = 16'h0000;
					3: next_mask = tuc_pkg::VERDICT_YES;
					4: next_mask = tuc_pkg::VERDICT_NO;
					default: next_mask = 16'($urandom);
				endcase
				load_mask(next_mask);
			end
			// The result side stalls for a long stretch while bytes keep coming.
			if (k == HOLD_AT) hold_request = 1'b1;
			// A pause with everything drained, but no mask change after it.
			if (k == PAUSE_AT) await_idle();
			if (k == LONG_BUFFER_AT)
				text = make_long_text();
			else
				text = make_text();
			send_text(text);
			bytes_sent += text.size();
			buffers_sent++;
			k++;
		end

		await_idle();
		if (failures == 0 && awaited.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/tuc_pkg.sv
rtl/tuc_front.sv
rtl/tuc_queue.sv
rtl/tuc_back.sv
rtl/text_unicode_classifier.sv
verif/testbench.sv
